>>> rtl/arx_stream_cipher_keystream_top_macros.svh
// Assertion macros shared by the keystream block.
`ifndef ARX_STREAM_CIPHER_KEYSTREAM_TOP_MACROS_SVH
`define ARX_STREAM_CIPHER_KEYSTREAM_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ARX_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ARX_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/arx_pkg.sv
// Types, constants and helper functions of the add-rotate-xor keystream block.
package arx_pkg;

   localparam int WORD_W     = 32;
   localparam int CFG_W      = 64;
   localparam int NUM_REGS   = 8;
   localparam int NUM_CFG    = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int STEP_W     = 3;
   localparam int ROT_AMOUNT = 2;

   localparam logic CMD_INIT = 1'b0;
   localparam logic CMD_DATA = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_PART0   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_PART1   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_PART2   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_PART3   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NONCE_PART0 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_NONCE_PART1 = 3'd5;

   localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;

   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_MIX,
      ST_FOLD
   } state_type;

   // Operands of one mixing round.
   typedef struct packed {
      word_type cur_reg;
      word_type next_reg;
      word_type chain;
      word_type count;
   } round_in_type;

   typedef struct packed {
      word_type new_reg;
      word_type new_chain;
   } round_out_type;

   // Register position folded in at each fold step; step 0 loads register 0.
   function automatic logic [STEP_W-1:0] fold_index(input logic [STEP_W-1:0] step);
      logic [STEP_W-1:0] idx;
      case (step)
         3'd0:    idx = 3'd0;
         3'd1:    idx = 3'd6;
         3'd2:    idx = 3'd1;
         3'd3:    idx = 3'd5;
         3'd4:    idx = 3'd2;
         3'd5:    idx = 3'd4;
         3'd6:    idx = 3'd3;
         default: idx = 3'd7;
      endcase
      return idx;
   endfunction

endpackage

>>> rtl/arx_round.sv
// One add-rotate-xor mixing round, shared by all eight rounds of a pass.
module arx_round (
   input  arx_pkg::round_in_type  round_in,
   output arx_pkg::round_out_type round_out
);

   arx_pkg::word_type sum_word;
   arx_pkg::word_type mixed_word;
   arx_pkg::word_type rot_word;

   always_comb begin
      sum_word   = round_in.cur_reg + round_in.next_reg + round_in.chain;
      mixed_word = sum_word ^ round_in.cur_reg;
      rot_word   = {mixed_word[arx_pkg::WORD_W-arx_pkg::ROT_AMOUNT-1:0],
                    mixed_word[arx_pkg::WORD_W-1:arx_pkg::WORD_W-arx_pkg::ROT_AMOUNT]};
      round_out.new_reg   = rot_word;
      round_out.new_chain = round_in.chain + rot_word + round_in.count;
   end

endmodule

>>> rtl/arx_stream_cipher_keystream_top.sv
// Top level of the add-rotate-xor keystream block: sequencer, state and ports.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   req     | in        | req_valid/req_stall  | req_command, req_data_word
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_cipher_word
//   csr     | in        | csr_write_en         | csr_index, csr_write_data
//
// A data beat runs 8 mixing rounds on the one shared round unit, then folds the
// registers serially through one adder/xor, the last fold step of which loads the
// result register. An init beat sums the loaded registers into the chain word,
// then runs 8 mixing rounds.
// Reset is synchronous and clears the sequencer, mixing, chain and counter state
// and the key and nonce registers, but not the data, fold and result words. A
// stalled result holds in its register; a data beat that finishes while the
// previous result is still stalled waits in its last fold step.
module arx_stream_cipher_keystream_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [arx_pkg::WORD_W-1:0]      req_data_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [arx_pkg::WORD_W-1:0]      rsp_cipher_word,
   input  logic                            csr_write_en,
   input  logic [arx_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [arx_pkg::CFG_W-1:0]       csr_write_data
);

   `include "arx_stream_cipher_keystream_top_macros.svh"

   // Key and nonce registers; they only take effect at the next init beat.
   logic [arx_pkg::CFG_W-1:0] cfg_ff [arx_pkg::NUM_CFG];

   // The mixing registers form a rotating line: during a pass, position 0
   // always holds the register being updated and position 1 its successor.
   // After eight rotations the line is back in its natural order.
   arx_pkg::word_type mix_ff [arx_pkg::NUM_REGS];
   arx_pkg::word_type mix_in [arx_pkg::NUM_REGS];

   arx_pkg::word_type chain_ff, chain_in;
   arx_pkg::word_type count_ff, count_in;

   arx_pkg::state_type state_ff, state_in;
   logic [arx_pkg::STEP_W-1:0] step_ff, step_in;
   logic init_ff, init_in;
   arx_pkg::word_type data_ff, data_in;
   arx_pkg::word_type fold_ff, fold_in;
   logic rsp_valid_ff, rsp_valid_in;
   arx_pkg::word_type rsp_word_ff, rsp_word_in;

   arx_pkg::round_in_type  round_in;
   arx_pkg::round_out_type round_out;

   arx_pkg::word_type fold_operand;
   logic req_fire;
   logic rsp_fire;

   assign req_stall       = (state_ff != arx_pkg::ST_IDLE);
   assign req_fire        = req_valid && !req_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cipher_word = rsp_word_ff;
   assign rsp_fire        = rsp_valid_ff && !rsp_stall;

   // Configuration writes; indexes past the list fall through every compare.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < arx_pkg::NUM_CFG; k++) begin
            cfg_ff[k] <= '0;
         end
      end else if (csr_write_en) begin
         for (int k = 0; k < arx_pkg::NUM_CFG; k++) begin
            if (csr_index == arx_pkg::CSR_INDEX_W'(k)) begin
               cfg_ff[k] <= csr_write_data;
            end
         end
      end
   end

   assign round_in.cur_reg  = mix_ff[0];
   assign round_in.next_reg = mix_ff[1];
   assign round_in.chain    = chain_ff;
   assign round_in.count    = count_ff;

   arx_round u_round (
      .round_in  (round_in),
      .round_out (round_out)
   );

   assign fold_operand = mix_ff[arx_pkg::fold_index(step_ff)];

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      init_in      = init_ff;
      data_in      = data_ff;
      fold_in      = fold_ff;
      chain_in     = chain_ff;
      count_in     = count_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_fire;
      for (int k = 0; k < arx_pkg::NUM_REGS; k++) begin
         mix_in[k] = mix_ff[k];
      end

      case (state_ff)
         arx_pkg::ST_IDLE: begin
            if (req_fire) begin
               init_in = (req_command == arx_pkg::CMD_INIT);
               data_in = req_data_word;
               step_in = '0;
               if (req_command == arx_pkg::CMD_INIT) begin
                  // Key words are big-endian: the upper half loads the even register.
                  mix_in[0] = cfg_ff[arx_pkg::CSR_KEY_PART0][63:32];
                  mix_in[1] = cfg_ff[arx_pkg::CSR_KEY_PART0][31:0];
                  mix_in[2] = cfg_ff[arx_pkg::CSR_KEY_PART1][63:32];
                  mix_in[3] = cfg_ff[arx_pkg::CSR_KEY_PART1][31:0];
                  mix_in[4] = cfg_ff[arx_pkg::CSR_KEY_PART2][63:32]
                            ^ cfg_ff[arx_pkg::CSR_NONCE_PART0][63:32];
                  mix_in[5] = cfg_ff[arx_pkg::CSR_KEY_PART2][31:0]
                            ^ cfg_ff[arx_pkg::CSR_NONCE_PART0][31:0];
                  mix_in[6] = cfg_ff[arx_pkg::CSR_KEY_PART3][63:32]
                            ^ cfg_ff[arx_pkg::CSR_NONCE_PART1][63:32];
                  mix_in[7] = cfg_ff[arx_pkg::CSR_KEY_PART3][31:0]
                            ^ cfg_ff[arx_pkg::CSR_NONCE_PART1][31:0];
                  chain_in  = '0;
                  count_in  = '0;
                  state_in  = arx_pkg::ST_SUM;
               end else begin
                  state_in = arx_pkg::ST_MIX;
               end
            end
         end

         arx_pkg::ST_SUM: begin
            // Accumulate the chain word one register per cycle while rotating.
            chain_in = chain_ff + mix_ff[0];
            for (int k = 0; k < arx_pkg::NUM_REGS - 1; k++) begin
               mix_in[k] = mix_ff[k+1];
            end
            mix_in[arx_pkg::NUM_REGS-1] = mix_ff[0];
            step_in = step_ff + 1'b1;
            if (step_ff == arx_pkg::STEP_LAST) begin
               state_in = arx_pkg::ST_MIX;
            end
         end

         arx_pkg::ST_MIX: begin
            for (int k = 0; k < arx_pkg::NUM_REGS - 1; k++) begin
               mix_in[k] = mix_ff[k+1];
            end
            mix_in[arx_pkg::NUM_REGS-1] = round_out.new_reg;
            chain_in = round_out.new_chain;
            count_in = count_ff + 1'b1;
            step_in  = step_ff + 1'b1;
            if (step_ff == arx_pkg::STEP_LAST) begin
               state_in = init_ff ? arx_pkg::ST_IDLE : arx_pkg::ST_FOLD;
            end
         end

         arx_pkg::ST_FOLD: begin
            // Odd steps add, even steps xor; step 0 just loads register 0.
            if (step_ff == '0) begin
               fold_in = fold_operand;
               step_in = step_ff + 1'b1;
            end else if (step_ff == arx_pkg::STEP_LAST) begin
               if (!rsp_valid_ff || rsp_fire) begin
                  rsp_word_in  = (fold_ff + fold_operand) ^ data_ff;
                  rsp_valid_in = 1'b1;
                  step_in      = '0;
                  state_in     = arx_pkg::ST_IDLE;
               end
            end else begin
               fold_in = step_ff[0] ? (fold_ff + fold_operand) : (fold_ff ^ fold_operand);
               step_in = step_ff + 1'b1;
            end
         end

         default: begin
            state_in = arx_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= arx_pkg::ST_IDLE;
         step_ff      <= '0;
         init_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         chain_ff     <= '0;
         count_ff     <= '0;
         for (int k = 0; k < arx_pkg::NUM_REGS; k++) begin
            mix_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
         count_ff     <= count_in;
         for (int k = 0; k < arx_pkg::NUM_REGS; k++) begin
            mix_ff[k] <= mix_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      fold_ff     <= fold_in;
      rsp_word_ff <= rsp_word_in;
   end

   // An init beat clears the chain word and counter and starts the summing phase.
   `ARX_ASSERT_NEXT(a_init_start, req_fire && (req_command == arx_pkg::CMD_INIT),
      (state_ff == arx_pkg::ST_SUM) && (chain_ff == '0) && (count_ff == '0),
      "init beat did not start the summing phase")

   // Every pass advances the counter by eight, so it is aligned whenever idle.
   `ARX_ASSERT_NOW(a_count_aligned, state_ff == arx_pkg::ST_IDLE,
      count_ff[arx_pkg::STEP_W-1:0] == '0,
      "step counter misaligned after a mixing pass")

   // A finished data pass always moves on to folding.
   `ARX_ASSERT_NEXT(a_mix_to_fold,
      (state_ff == arx_pkg::ST_MIX) && (step_ff == arx_pkg::STEP_LAST) && !init_ff,
      state_ff == arx_pkg::ST_FOLD,
      "data pass did not enter the fold phase")

   // A result only appears out of the last fold step.
   `ARX_ASSERT_NOW(a_rsp_from_fold, $rose(rsp_valid_ff),
      $past((state_ff == arx_pkg::ST_FOLD) && (step_ff == arx_pkg::STEP_LAST)),
      "result raised outside the last fold step")

endmodule
